>>> hw/rtl/zigzag_matrix_reorder_assert.svh
// Assertion helpers for the zigzag reorder block.
// Each macro expects clk and rst in scope.
`ifndef ZIGZAG_MATRIX_REORDER_ASSERT_SVH
`define ZIGZAG_MATRIX_REORDER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define ZZMR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zzmr assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ZZMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zzmr assertion failed");

`endif

>>> hw/rtl/zzmr_pkg.sv
package zzmr_pkg;

  localparam int MAX_DIM_DEFAULT = 8;

  // configuration register widths and indexes
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;
  localparam logic [CFG_W-1:0]     DIM_RESET     = 4'd8;

  localparam int ELEM_W = 32;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } zzmr_state_t;

endpackage

>>> hw/rtl/zigzag_matrix_reorder.sv
// channel   direction  handshake            payload
// cfg       in         cfg_write            cfg_index, cfg_data
// in        in         in_valid/in_ready    element
// out       out        out_valid/out_ready  element_out, frame_last
//
// Loading writes each accepted element into the element buffer; emission
// reads them out in zigzag order, paced by the single read port of the buffer.
// in_ready is low while the diagonal sequencer walks the buffer.
// A stalled output holds the sequencer; loading resumes as soon as the last
// read is issued. Reset clears the load count and sets both dimensions to 8.
`include "zigzag_matrix_reorder_assert.svh"

module zigzag_matrix_reorder #(
  parameter int MAX_DIM = zzmr_pkg::MAX_DIM_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [zzmr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [zzmr_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [zzmr_pkg::ELEM_W-1:0]   element,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [zzmr_pkg::ELEM_W-1:0]   element_out,
  output logic                                 frame_last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = $clog2(2 * MAX_DIM);

  logic [zzmr_pkg::CFG_W-1:0] row_count;
  logic [zzmr_pkg::CFG_W-1:0] col_count;
  logic [CW-1:0]              load_count;
  zzmr_pkg::zzmr_state_t      state, state_next;
  logic [DW-1:0]              diag;
  logic [DW-1:0]              pos;

  logic signed [zzmr_pkg::ELEM_W-1:0] store [DEPTH];

  logic [DW-1:0]   rows_d, cols_d;
  logic [2*DW-1:0] rows_w, cols_w;
  logic [CW-1:0]   total;
  logic [DW-1:0]   last_diag;
  logic [DW-1:0]   cur_hi, next_lo;
  logic [DW-1:0]   r_idx, c_idx;
  logic [2*DW-1:0] addr_full;
  logic            in_take;
  logic            frame_done;
  logic            out_load;
  logic            issue;
  logic            diag_end;

  function automatic logic [DW-1:0] clamp_dim(input logic [zzmr_pkg::CFG_W-1:0] raw);
    logic [DW-1:0] res;
    if (raw == '0) begin
      res = DW'(1);
    end else if (32'(raw) > MAX_DIM) begin
      res = DW'(MAX_DIM);
    end else begin
      res = DW'(raw);
    end
    return res;
  endfunction

  // first position on diagonal d: even diagonals clip on rows, odd on cols
  function automatic logic [DW-1:0] diag_lo(input logic [DW-1:0] d,
                                            input logic [DW-1:0] r,
                                            input logic [DW-1:0] c);
    logic [DW-1:0] lim;
    logic [DW-1:0] d1;
    lim = d[0] ? c : r;
    d1  = d + DW'(1);
    return (d1 > lim) ? (d1 - lim) : '0;
  endfunction

  function automatic logic [DW-1:0] diag_hi(input logic [DW-1:0] d,
                                            input logic [DW-1:0] r,
                                            input logic [DW-1:0] c);
    logic [DW-1:0] lim;
    lim = (d[0] ? r : c) - DW'(1);
    return (d < lim) ? d : lim;
  endfunction

  assign rows_d    = clamp_dim(row_count);
  assign cols_d    = clamp_dim(col_count);
  assign rows_w    = (2*DW)'(rows_d);
  assign cols_w    = (2*DW)'(cols_d);
  assign total     = CW'(rows_w * cols_w);
  assign last_diag = rows_d + cols_d - DW'(2);

  assign cur_hi   = diag_hi(diag, rows_d, cols_d);
  assign next_lo  = diag_lo(diag + DW'(1), rows_d, cols_d);
  assign diag_end = (pos == cur_hi);

  // even diagonal: pos is the column (moving up-right); odd: pos is the row
  assign r_idx     = diag[0] ? pos : (diag - pos);
  assign c_idx     = diag[0] ? (diag - pos) : pos;
  assign addr_full = (2*DW)'(r_idx) * cols_w + (2*DW)'(c_idx);

  assign in_take    = in_valid && in_ready;
  assign frame_done = (load_count + CW'(1)) == total;
  assign out_load   = !out_valid || out_ready;
  assign issue      = (state == zzmr_pkg::ST_EMIT) && out_load;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      zzmr_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_take && frame_done) begin
          state_next = zzmr_pkg::ST_EMIT;
        end
      end
      zzmr_pkg::ST_EMIT: begin
        if (issue && (diag == last_diag)) begin
          state_next = zzmr_pkg::ST_LOAD;
        end
      end
      default: state_next = zzmr_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= zzmr_pkg::ST_LOAD;
      row_count  <= zzmr_pkg::DIM_RESET;
      col_count  <= zzmr_pkg::DIM_RESET;
      load_count <= '0;
      diag       <= '0;
      pos        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          zzmr_pkg::REG_ROW_COUNT: row_count <= cfg_data;
          zzmr_pkg::REG_COL_COUNT: col_count <= cfg_data;
          default: ;
        endcase
        load_count <= '0;
      end else if (in_take) begin
        load_count <= frame_done ? '0 : (load_count + CW'(1));
      end
      if (in_take && frame_done) begin
        diag <= '0;
        pos  <= '0;
      end else if (issue) begin
        if (diag_end) begin
          diag <= diag + DW'(1);
          pos  <= next_lo;
        end else begin
          pos <= pos + DW'(1);
        end
      end
      if (out_load) begin
        out_valid <= (state == zzmr_pkg::ST_EMIT);
      end
    end
  end

  // buffer: one write port for loading, one registered read into the output
  always_ff @(posedge clk) begin
    if (in_take) begin
      store[load_count[AW-1:0]] <= element;
    end
    if (issue) begin
      element_out <= store[addr_full[AW-1:0]];
      frame_last  <= (diag == last_diag);
    end
  end

  `ZZMR_ASSERT_SAME(a_load_in_range, 1'b1, load_count < total)
  `ZZMR_ASSERT_NEXT(a_frame_start, in_take && frame_done,
                    (state == zzmr_pkg::ST_EMIT) && (load_count == '0) && (diag == '0))
  `ZZMR_ASSERT_SAME(a_pos_on_diag, state == zzmr_pkg::ST_EMIT,
                    (pos >= diag_lo(diag, rows_d, cols_d)) && (pos <= cur_hi))
  `ZZMR_ASSERT_SAME(a_emit_not_ready, state == zzmr_pkg::ST_EMIT, !in_ready)

endmodule

>>> verif/tb_zigzag_matrix_reorder.sv
`timescale 1ns / 100ps

module tb_zigzag_matrix_reorder;

  localparam int MAX_DIM    = zzmr_pkg::MAX_DIM_DEFAULT;
  localparam int CYCLE_CAP  = 300000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic signed [zzmr_pkg::ELEM_W-1:0] value;
    logic                               last;
  } scan_out_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_write = 1'b0;
  logic [zzmr_pkg::CFG_IDX_W-1:0]     cfg_index = zzmr_pkg::REG_ROW_COUNT;
  logic [zzmr_pkg::CFG_W-1:0]         cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [zzmr_pkg::ELEM_W-1:0] element = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [zzmr_pkg::ELEM_W-1:0] element_out;
  logic                               frame_last;

  zigzag_matrix_reorder #(.MAX_DIM(MAX_DIM)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .element(element),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .element_out(element_out),
    .frame_last(frame_last)
  );

  always #5 clk = ~clk;

  // shadow of the block state
  logic [zzmr_pkg::ELEM_W-1:0] matrix_shadow [MAX_DIM*MAX_DIM];
  logic [zzmr_pkg::CFG_W-1:0]  row_reg = zzmr_pkg::DIM_RESET;
  logic [zzmr_pkg::CFG_W-1:0]  col_reg = zzmr_pkg::DIM_RESET;
  int                          load_cnt = 0;

  logic [zzmr_pkg::ELEM_W-1:0] elem_queue [$];
  scan_out_t                   scan_queue [$];
  int                          queued_cnt = 0;
  int                          sent_cnt = 0;
  int                          err_cnt = 0;
  int                          cycle_cnt = 0;
  int                          send_idle_pct = 33;
  int                          recv_idle_pct = 58;
  int                          hold_requests = 0;
  int                          hold_served = 0;
  int                          hold_left = 0;
  logic                        req_accepted = 1'b0;

  function automatic int eff_dim(logic [zzmr_pkg::CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  // store one element; on the last one of the frame queue the zigzag scan
  function automatic void load_element(logic [zzmr_pkg::ELEM_W-1:0] v);
    int rows, cols, total, d, j, lo, hi, idx;
    scan_out_t item;
    rows  = eff_dim(row_reg);
    cols  = eff_dim(col_reg);
    total = rows * cols;
    if (load_cnt >= total) load_cnt = 0;
    matrix_shadow[load_cnt] = v;
    load_cnt++;
    if (load_cnt == total) begin
      idx = 0;
      for (d = 0; d < rows + cols - 1; d++) begin
        // even diagonals walk up-right (column rises), odd walk down-left
        if (d % 2 == 0) begin
          lo = (d + 1 > rows) ? d + 1 - rows : 0;
          hi = (d < cols - 1) ? d : cols - 1;
        end else begin
          lo = (d + 1 > cols) ? d + 1 - cols : 0;
          hi = (d < rows - 1) ? d : rows - 1;
        end
        for (j = lo; j <= hi; j++) begin
          if (d % 2 == 0) item.value = matrix_shadow[(d - j) * cols + j];
          else item.value = matrix_shadow[j * cols + (d - j)];
          idx++;
          item.last = (idx == total);
          scan_queue.push_back(item);
        end
      end
      load_cnt = 0;
    end
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!in_valid || req_accepted) begin
      if (elem_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        element  <= elem_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: config writes, accepted requests, accepted results
  always @(posedge clk) begin
    scan_out_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end else begin
      req_accepted <= !rst && in_valid && in_ready;
      if (!rst) begin
        if (cfg_write) begin
          if (cfg_index == zzmr_pkg::REG_ROW_COUNT) row_reg = cfg_data;
          else if (cfg_index == zzmr_pkg::REG_COL_COUNT) col_reg = cfg_data;
          load_cnt = 0;
        end
        if (in_valid && in_ready) begin
          load_element(element);
          sent_cnt++;
        end
        if (out_valid && out_ready) begin
          if (scan_queue.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("unexpected result: element_out %h frame_last %0b",
                       element_out, frame_last);
          end else begin
            want = scan_queue.pop_front();
            if (element_out !== want.value || frame_last !== want.last) begin
              err_cnt++;
              if (err_cnt <= 10)
                $display("mismatch: element_out exp %h got %h, frame_last exp %0b got %0b",
                         want.value, element_out, want.last, frame_last);
            end
          end
        end
      end
    end
  end

  task automatic push_value(logic [zzmr_pkg::ELEM_W-1:0] v);
    elem_queue.push_back(v);
    queued_cnt++;
  endtask

  task automatic push_frame(int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(11))
        0: push_value(32'h8000_0000);
        1: push_value(32'h7fff_ffff);
        2: push_value('0);
        3: push_value('1);
        default: push_value($urandom);
      endcase
    end
  endtask

  // wait until every request is taken and every result has come back
  task automatic settle();
    while (sent_cnt != queued_cnt) @(posedge clk);
    while (scan_queue.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_reg(logic [zzmr_pkg::CFG_IDX_W-1:0] idx,
                         logic [zzmr_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [zzmr_pkg::CFG_W-1:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return (zzmr_pkg::CFG_W)'($urandom_range(MAX_DIM + 1, 15));
    if (r < 24) return (zzmr_pkg::CFG_W)'(MAX_DIM);
    return (zzmr_pkg::CFG_W)'($urandom_range(1, 5));
  endfunction

  initial begin
    int ph, goal, nfr, total, k;
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // partial frame at reset size, then dropped by a write
    push_value(32'h8000_0000);
    push_value(32'h7fff_ffff);
    push_value('0);
    push_value('1);
    push_value(32'h0000_0001);
    settle();
    // single column, row count still at reset
    set_reg(zzmr_pkg::REG_COL_COUNT, 4'd1);
    push_frame(8);
    settle();
    // zero acts as one: 1x1
    set_reg(zzmr_pkg::REG_ROW_COUNT, 4'd0);
    push_value(32'h8000_0000);
    push_value(32'h7fff_ffff);
    settle();
    // oversize acts as the maximum: single row of 8
    set_reg(zzmr_pkg::REG_COL_COUNT, 4'hf);
    push_frame(8);
    settle();
    set_reg(zzmr_pkg::REG_ROW_COUNT, 4'd3);
    set_reg(zzmr_pkg::REG_COL_COUNT, 4'd2);
    push_frame(6);

    for (ph = 0; ph < 3; ph++) begin
      settle();
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 58 : 0;
      recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 33 : 0;
      goal = queued_cnt + 20;
      if (ph == 2) begin
        // long receiver stall with frames queued behind it
        set_reg(zzmr_pkg::REG_ROW_COUNT, 4'd3);
        set_reg(zzmr_pkg::REG_COL_COUNT, 4'd3);
        push_frame(27);
        hold_requests++;
        settle();
      end
      while (queued_cnt < goal) begin
        settle();
        if ($urandom_range(3) != 0) set_reg(zzmr_pkg::REG_ROW_COUNT, pick_dim());
        if ($urandom_range(3) != 0) set_reg(zzmr_pkg::REG_COL_COUNT, pick_dim());
        total = eff_dim(row_reg) * eff_dim(col_reg);
        nfr = (total > 16) ? 1 : $urandom_range(1, 3);
        for (k = 0; k < nfr; k++) push_frame(total);
        // sometimes leave a partial frame for the next write to drop
        if (total > 1 && $urandom_range(4) == 0) push_frame($urandom_range(1, total - 1));
      end
    end

    settle();
    repeat (150) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
